@@ design/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants, codes and control types of the periodic task scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int KIND_W     = 3;
   localparam int IDX_W      = 8;
   localparam int PERIOD_W   = 16;
   localparam int DELAY_W    = 8;
   localparam int CD_W       = 16;
   localparam int FIRE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_CREATE  = 3'd1,
      KIND_SUSPEND = 3'd2,
      KIND_RESUME  = 3'd3,
      KIND_DELETE  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_RESERVED  = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic exec;
      logic scan_clear;
      logic scan_step;
      logic load_tick;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_last;
   } dp_stat_type;

endpackage

@@ design/ptts_dp.sv @@
// ----------------------------------------------------------------------------
// ptts_dp
// Slot table, one-slot-per-cycle tick update and result register.
// ----------------------------------------------------------------------------
module ptts_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptts_pkg::KIND_W-1:0]         req_tuser,
   input  logic [ptts_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  ptts_pkg::ctl_cmd_type               cmd,
   output ptts_pkg::dp_stat_type               stat,
   output logic [ptts_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import ptts_pkg::*;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] susp_ff, susp_in;
   logic [PERIOD_W-1:0]  period_ff [NUM_SLOTS];
   logic [CD_W-1:0]      cd_ff [NUM_SLOTS];
   logic [SLOT_W-1:0]    cnt_ff, cnt_in;
   logic [FIRE_W-1:0]    mask_ff, mask_in;
   logic [FIRE_W-1:0]    out_mask_ff, out_mask_in;
   status_type           out_status_ff, out_status_in;

   logic [IDX_W-1:0]     cmd_idx;
   logic [PERIOD_W-1:0]  cmd_period;
   logic [DELAY_W-1:0]   cmd_delay;
   logic [SLOT_W-1:0]    cmd_slot;
   logic                 bad_idx;
   logic [CD_W-1:0]      cur_cd;
   logic [PERIOD_W-1:0]  cur_per;
   logic                 live;
   logic                 hit;
   logic [FIRE_W-1:0]    fire_bits;
   logic                 per_wr_en;
   logic                 cd_wr_en;
   logic [SLOT_W-1:0]    wr_idx;
   logic [PERIOD_W-1:0]  per_wr_in;
   logic [CD_W-1:0]      cd_wr_in;

   assign cmd_idx    = req_tdata[IDX_W-1:0];
   assign cmd_period = req_tdata[IDX_W +: PERIOD_W];
   assign cmd_delay  = req_tdata[IDX_W+PERIOD_W +: DELAY_W];
   assign cmd_slot   = cmd_idx[SLOT_W-1:0];
   assign bad_idx    = cmd_idx >= IDX_W'(NUM_SLOTS);

   assign cur_cd  = cd_ff[cnt_ff];
   assign cur_per = period_ff[cnt_ff];
   assign live    = valid_ff[cnt_ff] && !susp_ff[cnt_ff];
   assign hit     = live && (cur_cd == '0);

   always_comb begin
      for (int j = 0; j < FIRE_W; j++) begin
         fire_bits[j] = hit && (int'(cnt_ff) == j);
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      susp_in       = susp_ff;
      cnt_in        = cnt_ff;
      mask_in       = mask_ff;
      out_mask_in   = out_mask_ff;
      out_status_in = out_status_ff;
      per_wr_en     = 1'b0;
      cd_wr_en      = 1'b0;
      wr_idx        = cnt_ff;
      per_wr_in     = cmd_period;
      cd_wr_in      = hit ? CD_W'(cur_per) : cur_cd - CD_W'(1);

      if (cmd.scan_clear) begin
         cnt_in  = '0;
         mask_in = '0;
      end

      if (cmd.scan_step) begin
         cnt_in   = cnt_ff + SLOT_W'(1);
         mask_in  = mask_ff | fire_bits;
         cd_wr_en = live;
      end

      if (cmd.load_tick) begin
         out_mask_in   = mask_ff | fire_bits;
         out_status_in = ST_OK;
      end

      if (cmd.exec) begin
         out_mask_in   = '0;
         out_status_in = ST_OK;
         unique case (req_tuser)
            KIND_CREATE: begin
               if (bad_idx) begin
                  out_status_in = ST_BAD_INDEX;
               end else if (valid_ff[cmd_slot]) begin
                  out_status_in = ST_RESERVED;
               end else begin
                  valid_in[cmd_slot] = 1'b1;
                  susp_in[cmd_slot]  = 1'b0;
                  per_wr_en          = 1'b1;
                  cd_wr_en           = 1'b1;
                  wr_idx             = cmd_slot;
                  cd_wr_in           = CD_W'(cmd_delay);
               end
            end
            KIND_SUSPEND: begin
               if (bad_idx) out_status_in = ST_BAD_INDEX;
               else susp_in[cmd_slot] = 1'b1;
            end
            KIND_RESUME: begin
               if (bad_idx) out_status_in = ST_BAD_INDEX;
               else susp_in[cmd_slot] = 1'b0;
            end
            KIND_DELETE: begin
               if (bad_idx) out_status_in = ST_BAD_INDEX;
               else valid_in[cmd_slot] = 1'b0;
            end
            default: begin
               out_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         susp_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         susp_ff  <= susp_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      out_mask_ff   <= out_mask_in;
      out_status_ff <= out_status_in;
      if (per_wr_en) period_ff[wr_idx] <= per_wr_in;
      if (cd_wr_en) cd_ff[wr_idx] <= cd_wr_in;
   end

   assign stat.is_tick   = (req_tuser == KIND_TICK);
   assign stat.scan_last = (cnt_ff == SLOT_W'(NUM_SLOTS - 1));

   assign rsp_tdata = {{(RSP_DATA_W - FIRE_W - STATUS_W){1'b0}}, out_status_ff, out_mask_ff};

endmodule

@@ design/ptts_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptts_ctrl
// Handshake control and slot scan sequencing of the task scheduler.
// ----------------------------------------------------------------------------
module ptts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ptts_pkg::dp_stat_type  stat,
   output ptts_pkg::ctl_cmd_type  cmd
);
   import ptts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.is_tick) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.exec     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               cmd.load_tick = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_scan_output_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during slot scan");

   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.is_tick) |=> (state_ff == S_SCAN))
      else $error("accepted tick did not start a scan");

   a_scan_end_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && stat.scan_last) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("scan end did not present a result");

endmodule

@@ design/periodic_task_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered periodic task table driven by tick and slot commands.
// ----------------------------------------------------------------------------
// Create, suspend, resume and delete commands (and unused kinds) return their
// status beat in the cycle after they are accepted. During a tick, one shared
// countdown unit visits one table slot per cycle, firing and reloading or
// decrementing it, and the fire mask beat follows the last slot. A new beat
// is taken in the cycle the previous result is drained, but not during a scan.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] kind
   input  logic [ptts_pkg::KIND_W-1:0]         req_tuser,
   // [7:0] task_index, [23:8] period, [31:24] start_delay
   input  logic [ptts_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] fire_mask, [9:8] status, [15:10] zero
   output logic [ptts_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import ptts_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   ptts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ptts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the periodic task scheduler against a cycle-free model of its slot
// table. Directed command sequences cover create, suspend, resume, delete,
// bad indexes, unused kinds and ticks. Random traffic then runs under
// changing stalls on both streams. Every status or fire-mask beat is
// compared in order with the beat that the model predicts.
// ----------------------------------------------------------------------------
module testbench;
   import ptts_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [FIRE_W-1:0] fire_mask;
      status_type        status;
   } fire_status_type;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [2:0] kind
   logic [KIND_W-1:0] req_tuser = '0;
   // [7:0] task_index, [23:8] period, [31:24] start_delay
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [7:0] fire_mask, [9:8] status, [15:10] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  slot_live  [NUM_SLOTS];
   logic                  slot_held  [NUM_SLOTS];
   logic [PERIOD_W-1:0]   slot_reload[NUM_SLOTS];
   logic [CD_W-1:0]       slot_count [NUM_SLOTS];

   fire_status_type fire_status_q[$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int fail_count    = 0;
   int idle_cycles   = 0;

   periodic_task_tick_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic fire_status_type compute_fire_status(input logic [KIND_W-1:0] kind,
                                                           input logic [IDX_W-1:0] idx,
                                                           input logic [PERIOD_W-1:0] per,
                                                           input logic [DELAY_W-1:0] dly);
      fire_status_type   res;
      logic [SLOT_W-1:0] s;
      s             = idx[SLOT_W-1:0];
      res.fire_mask = '0;
      res.status    = ST_OK;
      if (kind == KIND_TICK) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && !slot_held[i]) begin
               if (slot_count[i] == '0) begin
                  if (i < FIRE_W) res.fire_mask[i] = 1'b1;
                  slot_count[i] = slot_reload[i];
               end else begin
                  slot_count[i] = slot_count[i] - 1'b1;
               end
            end
         end
      end else if (kind == KIND_CREATE || kind == KIND_SUSPEND ||
                   kind == KIND_RESUME || kind == KIND_DELETE) begin
         if (idx >= NUM_SLOTS) begin
            res.status = ST_BAD_INDEX;
         end else if (kind == KIND_CREATE) begin
            if (slot_live[s]) begin
               res.status = ST_RESERVED;
            end else begin
               slot_live[s]   = 1'b1;
               slot_held[s]   = 1'b0;
               slot_reload[s] = per;
               slot_count[s]  = CD_W'(dly);
            end
         end else if (kind == KIND_SUSPEND) begin
            slot_held[s] = 1'b1;
         end else if (kind == KIND_RESUME) begin
            slot_held[s] = 1'b0;
         end else begin
            slot_live[s] = 1'b0;
         end
      end
      return res;
   endfunction

   task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] per, input logic [DELAY_W-1:0] dly);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {dly, per, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fire_status_q.push_back(compute_fire_status(kind, idx, per, dly));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fire_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random;
      int unsigned r;
      logic [KIND_W-1:0]   kind;
      logic [IDX_W-1:0]    idx;
      logic [PERIOD_W-1:0] per;
      logic [DELAY_W-1:0]  dly;
      r    = $urandom_range(99);
      idx  = ($urandom_range(15) == 0) ? IDX_W'($urandom_range(NUM_SLOTS, 255))
                                       : IDX_W'($urandom_range(NUM_SLOTS - 1));
      per  = ($urandom_range(19) == 0) ? PERIOD_W'($urandom)
           : ($urandom_range(5) == 0)  ? PERIOD_W'($urandom_range(255))
                                       : PERIOD_W'($urandom_range(7));
      dly  = ($urandom_range(3) == 0)  ? DELAY_W'($urandom) : DELAY_W'($urandom_range(7));
      if (r < 45) begin
         kind = KIND_TICK;
         idx  = IDX_W'($urandom);
      end else if (r < 65) begin
         kind = KIND_CREATE;
      end else if (r < 75) begin
         kind = KIND_SUSPEND;
      end else if (r < 85) begin
         kind = KIND_RESUME;
      end else if (r < 94) begin
         kind = KIND_DELETE;
      end else begin
         kind = KIND_W'($urandom_range(5, 7));
         idx  = IDX_W'($urandom);
      end
      send_cmd(kind, idx, per, dly);
   endtask

   task automatic test_idle_table;
      send_cmd(KIND_TICK, 8'hFF, 16'hFFFF, 8'hFF);
      for (int k = 5; k < 8; k++) begin
         send_cmd(KIND_W'(k), IDX_W'($urandom), PERIOD_W'($urandom), DELAY_W'($urandom));
      end
   endtask

   task automatic test_create_rules;
      send_cmd(KIND_CREATE, 8'd0, 16'h0000, 8'h00);
      send_cmd(KIND_CREATE, 8'd0, 16'h5555, 8'h55);
      send_cmd(KIND_CREATE, IDX_W'(NUM_SLOTS - 1), 16'hFFFF, 8'hFF);
      send_cmd(KIND_CREATE, IDX_W'(NUM_SLOTS), 16'h1234, 8'h01);
      send_cmd(KIND_CREATE, 8'hFF, 16'hAAAA, 8'hAA);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
   endtask

   task automatic test_slot_marks;
      send_cmd(KIND_SUSPEND, 8'd0, 16'h0000, 8'h00);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
      send_cmd(KIND_RESUME, 8'd0, 16'h0000, 8'h00);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
      send_cmd(KIND_SUSPEND, 8'd3, 16'h0000, 8'h00);
      send_cmd(KIND_RESUME, 8'd5, 16'h0000, 8'h00);
      send_cmd(KIND_DELETE, 8'd6, 16'h0000, 8'h00);
      send_cmd(KIND_SUSPEND, 8'hFF, 16'h0000, 8'h00);
      send_cmd(KIND_RESUME, IDX_W'(NUM_SLOTS), 16'h0000, 8'h00);
      send_cmd(KIND_DELETE, 8'd200, 16'h0000, 8'h00);
      send_cmd(KIND_DELETE, 8'd0, 16'h0000, 8'h00);
      send_cmd(KIND_CREATE, 8'd0, 16'h0001, 8'h00);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
      send_cmd(KIND_TICK, 8'h00, 16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int rcv_pct);
      send_idle_pct = send_pct;
      rcv_idle_pct  = rcv_pct;
      for (int n = 0; n < count; n++) send_random();
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      hold_token   <= hold_token + 1;
      for (int n = 0; n < 40; n++) send_random();
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left   = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      fire_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fire_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected beat: fire_mask=%h status=%0d",
                        rsp_tdata[7:0], rsp_tdata[9:8]);
         end else begin
            want = fire_status_q.pop_front();
            if (rsp_tdata[7:0] !== want.fire_mask || rsp_tdata[9:8] !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: fire_mask exp=%h got=%h, status exp=%0d got=%0d",
                           want.fire_mask, rsp_tdata[7:0], want.status, rsp_tdata[9:8]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_live[i]   = 1'b0;
         slot_held[i]   = 1'b0;
         slot_reload[i] = '0;
         slot_count[i]  = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_table();
      test_create_rules();
      test_slot_marks();
      drain();
      test_random_traffic(430, 17, 56);
      test_backpressure();
      test_random_traffic(430, 56, 17);
      test_random_traffic(430, 0, 0);
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && fire_status_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/ptts_pkg.sv
design/ptts_dp.sv
design/ptts_ctrl.sv
design/periodic_task_tick_scheduler.sv
test/testbench.sv
